// ===== design/lwsa_pkg.sv =====
// shared constants and types for the lattice walk checker
package lwsa_pkg;

	localparam int MAX_STEPS_DEF  = 64;
	localparam int COORD_BITS_DEF = 8;

	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int DIR_W      = 3;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH_Z = 3'd6;

	localparam logic [CFG_W-1:0] SIZE_RST  = 8'd10;
	localparam logic [CFG_W-1:0] COORD_RST = 8'd4;

	// step codes
	localparam logic [DIR_W-1:0] DIR_XP = 3'd1;
	localparam logic [DIR_W-1:0] DIR_YP = 3'd2;
	localparam logic [DIR_W-1:0] DIR_ZP = 3'd3;
	localparam logic [DIR_W-1:0] DIR_XN = 3'd4;
	localparam logic [DIR_W-1:0] DIR_YN = 3'd5;
	localparam logic [DIR_W-1:0] DIR_ZN = 3'd6;

	// verdicts
	localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SELF = 3'd1;
	localparam logic [STATUS_W-1:0] ST_END  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LONG = 3'd4;

	// status of the serial modulo unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CFG_W-1:0] rem;
	} mod_stat_t;

endpackage

// ===== design/lwsa_cell.sv =====
// one storage cell of the visited-site chain with its own match compare
module lwsa_cell #(
	parameter int SITE_W = 24,
	parameter int FILL_W = 7,
	parameter int IDX    = 0
) (
	input  logic              clk,
	input  logic              shift,
	input  logic [SITE_W-1:0] d_in,
	input  logic [SITE_W-1:0] probe,
	input  logic [FILL_W-1:0] fill,
	output logic [SITE_W-1:0] d_out,
	output logic              match
);

	logic [SITE_W-1:0] site_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			site_q <= d_in;
		end
	end

	assign d_out = site_q;
	assign match = (FILL_W'(IDX) < fill) && (site_q == probe);

endmodule

// ===== design/lwsa_mod_unit.sv =====
// bit-serial remainder of a coordinate by the lattice size
module lwsa_mod_unit #(
	parameter int COORD_BITS = lwsa_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [COORD_BITS-1:0]       dividend,
	input  logic [lwsa_pkg::CFG_W-1:0]  divisor,
	output lwsa_pkg::mod_stat_t         stat
);

	localparam int W     = lwsa_pkg::CFG_W;
	localparam int CNT_W = $clog2(COORD_BITS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     r_q;
	logic [W-1:0]     d_q;
	logic [COORD_BITS-1:0] sh_q;
	logic [W:0]       trial;

	assign trial = {r_q, sh_q[COORD_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(COORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			r_q  <= '0;
			sh_q <= dividend;
			d_q  <= divisor;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			if (trial >= {1'b0, d_q}) begin
				r_q <= W'(trial - {1'b0, d_q});
			end else begin
				r_q <= trial[W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = r_q;

endmodule

// ===== design/lattice_walk_self_avoid_check.sv =====
// top level of the self-avoiding walk checker on a periodic cubic lattice
//
// input channel: in_valid/in_ready with direction and last_step, one step per transfer.
// the first transfer after a verdict opens a new walk at the configured start site.
// output channel: out_valid/out_ready with status and step_count, one transfer per walk,
// presented the cycle after the transfer that carries last_step.
// throughput: one step per cycle while in_ready is high; every site visited after the
// start sits in a chain of MAX_STEPS cells that all compare against the next site in the
// same cycle. a step along an axis whose coordinate is at or above lattice_size (start
// off the lattice, or size changed) first runs the serial modulo unit with in_ready low,
// then the step goes through.
// a held verdict does not block steps of the next walk; only its last step waits
// for the output register to empty.
// the user writes configuration (cfg_we/cfg_index/cfg_data) only while idle; unchecked.
// reset: registers take their reset values, no walk is open, output is empty.
module lattice_walk_self_avoid_check #(
	parameter int MAX_STEPS  = lwsa_pkg::MAX_STEPS_DEF,
	parameter int COORD_BITS = lwsa_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lwsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lwsa_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lwsa_pkg::DIR_W-1:0]     direction,
	input  logic                           last_step,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lwsa_pkg::STATUS_W-1:0]  status,
	output logic [lwsa_pkg::COUNT_W-1:0]   step_count
);

	localparam int CB     = COORD_BITS;
	localparam int SITE_W = 3 * CB;
	localparam int AW     = ((CB > lwsa_pkg::CFG_W) ? CB : lwsa_pkg::CFG_W) + 1;
	localparam int FW     = $clog2(MAX_STEPS + 1);
	localparam int SW     = $clog2(MAX_STEPS + 2);
	localparam int CW     = lwsa_pkg::CFG_W;
	localparam int STW    = lwsa_pkg::STATUS_W;

	// configuration registers
	logic [CW-1:0] size_q, sx_q, sy_q, sz_q, fx_q, fy_q, fz_q;

	// walk state
	logic              walk_open_q;
	logic [SITE_W-1:0] cur_q;
	logic [SITE_W-1:0] start_q;
	logic [SW-1:0]     steps_q;
	logic [FW-1:0]     fill_q;
	logic [STW-1:0]    status_q;
	logic              mod_ok_q;
	logic [CW-1:0]     mod_val_q;

	logic                         out_valid_q;
	logic [STW-1:0]               out_status_q;
	logic [lwsa_pkg::COUNT_W-1:0] out_count_q;

	logic [SITE_W-1:0] start_cfg, finish_cfg, cur, entry0, next_site, cur_new;
	logic [CB-1:0]     c, nxt_c;
	logic [AW-1:0]     c_ext, cx, n_eff, nxt_w;
	logic [1:0]        axis;
	logic              up, dir_ok;
	logic [SW-1:0]     steps_old, steps_new;
	logic [FW-1:0]     fill_old;
	logic [STW-1:0]    status_old, st_new, st_final;
	logic              live, too_long, need_mod, hit, exc, appended, acc, mod_start;
	logic [MAX_STEPS-1:0] match_w;
	logic [SITE_W-1:0] chain_in  [MAX_STEPS];
	logic [SITE_W-1:0] chain_out [MAX_STEPS];
	lwsa_pkg::mod_stat_t mod_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= lwsa_pkg::SIZE_RST;
			sx_q   <= lwsa_pkg::COORD_RST;
			sy_q   <= lwsa_pkg::COORD_RST;
			sz_q   <= lwsa_pkg::COORD_RST;
			fx_q   <= lwsa_pkg::COORD_RST;
			fy_q   <= lwsa_pkg::COORD_RST;
			fz_q   <= lwsa_pkg::COORD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lwsa_pkg::CFG_SIZE:     size_q <= cfg_data;
				lwsa_pkg::CFG_START_X:  sx_q   <= cfg_data;
				lwsa_pkg::CFG_START_Y:  sy_q   <= cfg_data;
				lwsa_pkg::CFG_START_Z:  sz_q   <= cfg_data;
				lwsa_pkg::CFG_FINISH_X: fx_q   <= cfg_data;
				lwsa_pkg::CFG_FINISH_Y: fy_q   <= cfg_data;
				lwsa_pkg::CFG_FINISH_Z: fz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign start_cfg  = {CB'(sz_q), CB'(sy_q), CB'(sx_q)};
	assign finish_cfg = {CB'(fz_q), CB'(fy_q), CB'(fx_q)};
	assign n_eff      = (size_q == '0) ? AW'(1) : AW'(size_q);

	assign cur        = walk_open_q ? cur_q : start_cfg;
	assign entry0     = walk_open_q ? start_q : start_cfg;
	assign steps_old  = walk_open_q ? steps_q : '0;
	assign fill_old   = walk_open_q ? fill_q : '0;
	assign status_old = walk_open_q ? status_q : lwsa_pkg::ST_OK;

	always_comb begin
		axis   = 2'd0;
		up     = 1'b1;
		dir_ok = 1'b1;
		case (direction)
			lwsa_pkg::DIR_XP: begin axis = 2'd0; up = 1'b1; end
			lwsa_pkg::DIR_YP: begin axis = 2'd1; up = 1'b1; end
			lwsa_pkg::DIR_ZP: begin axis = 2'd2; up = 1'b1; end
			lwsa_pkg::DIR_XN: begin axis = 2'd0; up = 1'b0; end
			lwsa_pkg::DIR_YN: begin axis = 2'd1; up = 1'b0; end
			lwsa_pkg::DIR_ZN: begin axis = 2'd2; up = 1'b0; end
			default: dir_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (axis)
			2'd1:    c = cur[2*CB-1:CB];
			2'd2:    c = cur[3*CB-1:2*CB];
			default: c = cur[CB-1:0];
		endcase
	end

	assign c_ext = AW'(c);
	assign cx    = mod_ok_q ? AW'(mod_val_q) : c_ext;

	always_comb begin
		if (up) begin
			nxt_w = ((cx + AW'(1)) == n_eff) ? '0 : cx + AW'(1);
		end else begin
			nxt_w = (cx == '0) ? n_eff - AW'(1) : cx - AW'(1);
		end
	end

	assign nxt_c = CB'(nxt_w);

	always_comb begin
		next_site = cur;
		case (axis)
			2'd1:    next_site[2*CB-1:CB]   = nxt_c;
			2'd2:    next_site[3*CB-1:2*CB] = nxt_c;
			default: next_site[CB-1:0]      = nxt_c;
		endcase
	end

	assign steps_new = steps_old + SW'(steps_old <= SW'(MAX_STEPS));
	assign too_long  = steps_new > SW'(MAX_STEPS);
	assign live      = (status_old == lwsa_pkg::ST_OK);
	assign need_mod  = live && dir_ok && !too_long && (c_ext >= n_eff) && !mod_ok_q;

	assign in_ready  = !need_mod && (!out_valid_q || out_ready || !last_step);
	assign acc       = in_valid && in_ready;
	assign mod_start = in_valid && need_mod && !mod_stat.busy && !mod_stat.done;

	lwsa_mod_unit #(
		.COORD_BITS(CB)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (c),
		.divisor  (CW'(n_eff)),
		.stat     (mod_stat)
	);

	// site chain
	genvar gi;
	generate
		for (gi = 0; gi < MAX_STEPS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign chain_in[gi] = next_site;
			end else begin : g_link
				assign chain_in[gi] = chain_out[gi-1];
			end
			lwsa_cell #(
				.SITE_W (SITE_W),
				.FILL_W (FW),
				.IDX    (gi)
			) u_cell (
				.clk   (clk),
				.shift (acc && appended),
				.d_in  (chain_in[gi]),
				.probe (next_site),
				.fill  (fill_old),
				.d_out (chain_out[gi]),
				.match (match_w[gi])
			);
		end
	endgenerate

	assign hit = (next_site == entry0) || (|match_w);
	assign exc = last_step && (start_cfg == finish_cfg);

	always_comb begin
		appended = 1'b0;
		if (!live) begin
			st_new = status_old;
		end else if (!dir_ok) begin
			st_new = lwsa_pkg::ST_BAD;
		end else if (too_long) begin
			st_new = lwsa_pkg::ST_LONG;
		end else if (hit && !exc) begin
			st_new = lwsa_pkg::ST_SELF;
		end else begin
			st_new   = lwsa_pkg::ST_OK;
			appended = 1'b1;
		end
	end

	assign cur_new  = appended ? next_site : cur;
	assign st_final = ((st_new == lwsa_pkg::ST_OK) && (cur_new != finish_cfg)) ?
		lwsa_pkg::ST_END : st_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_open_q <= 1'b0;
			steps_q     <= '0;
			fill_q      <= '0;
			status_q    <= lwsa_pkg::ST_OK;
			mod_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mod_stat.done) begin
				mod_ok_q <= 1'b1;
			end
			if (acc) begin
				walk_open_q <= !last_step;
				steps_q     <= steps_new;
				fill_q      <= fill_old + FW'(appended);
				status_q    <= st_new;
				mod_ok_q    <= 1'b0;
			end
			if (acc && last_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mod_stat.done) begin
			mod_val_q <= mod_stat.rem;
		end
		if (acc) begin
			cur_q   <= cur_new;
			start_q <= entry0;
		end
		if (acc && last_step) begin
			out_status_q <= st_final;
			out_count_q  <= too_long ? lwsa_pkg::COUNT_W'(MAX_STEPS) :
				lwsa_pkg::COUNT_W'(steps_new);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign step_count = out_count_q;

endmodule

// ===== design/lwsa_checker.sv =====
// port-level checks for the lattice walk checker, bound to the top level
module lwsa_checker #(
	parameter int MAX_STEPS = lwsa_pkg::MAX_STEPS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          last_step,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lwsa_pkg::STATUS_W-1:0] status,
	input logic [lwsa_pkg::COUNT_W-1:0]  step_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(step_count))
		else $error("verdict changed while stalled");

	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_step |=> out_valid)
		else $error("last step transfer without verdict");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == lwsa_pkg::ST_OK || status == lwsa_pkg::ST_SELF ||
			status == lwsa_pkg::ST_END || status == lwsa_pkg::ST_BAD ||
			status == lwsa_pkg::ST_LONG)
		else $error("unknown status code");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_count != '0)
		else $error("verdict for a walk with no steps");

	a_long_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == lwsa_pkg::ST_LONG |->
			step_count == lwsa_pkg::COUNT_W'(MAX_STEPS))
		else $error("too-long verdict without saturated count");

endmodule

bind lattice_walk_self_avoid_check lwsa_checker #(
	.MAX_STEPS(MAX_STEPS)
) u_lwsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.last_step  (last_step),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.step_count (step_count)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the periodic cubic lattice walk checker
module tb_top;

	localparam int WALK_MAX      = lwsa_pkg::MAX_STEPS_DEF;
	localparam int SETTLE_CYCLES = lwsa_pkg::COORD_BITS_DEF + 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;

	localparam logic [lwsa_pkg::DIR_W-1:0] DIR_NUL = 3'd0;
	localparam logic [lwsa_pkg::DIR_W-1:0] DIR_ILL = 3'd7;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z;
	} site_t;

	typedef struct packed {
		logic [lwsa_pkg::STATUS_W-1:0] status;
		logic [lwsa_pkg::COUNT_W-1:0]  count;
	} verdict_t;

	typedef struct packed {
		logic [lwsa_pkg::DIR_W-1:0] dir;
		logic                       last;
	} move_t;

	typedef struct packed {
		logic [lwsa_pkg::DIR_W-1:0]    dir;
		logic                          last;
		logic                          typed;
		logic [lwsa_pkg::STATUS_W-1:0] st;
		logic [lwsa_pkg::COUNT_W-1:0]  cnt;
	} row_t;

	typedef struct packed {
		logic [7:0] size;
		logic [7:0] hx, hy, hz;
		logic [7:0] gx, gy, gz;
	} setting_t;

	typedef enum {WALK_LOOP, WALK_PATH, WALK_RAMBLE, WALK_SNAKE, WALK_NOISE} walk_kind_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [lwsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lwsa_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [lwsa_pkg::DIR_W-1:0]     direction = '0;
	logic                           last_step = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [lwsa_pkg::STATUS_W-1:0]  status;
	logic [lwsa_pkg::COUNT_W-1:0]   step_count;

	lattice_walk_self_avoid_check uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.direction(direction), .last_step(last_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .step_count(step_count)
	);

	always #5 clk = ~clk;

	// walk predictor state
	logic [7:0] lat_size;
	logic [7:0] home_x, home_y, home_z;
	logic [7:0] goal_x, goal_y, goal_z;
	site_t      trail [0:WALK_MAX];
	int         trail_len;
	site_t      here;
	logic [lwsa_pkg::STATUS_W-1:0] verdict_now;
	bit         walk_live;
	int         steps_taken;

	verdict_t   pending_verdicts [$];
	move_t      route [$];

	int  mismatches = 0;
	int  steps_sent = 0;
	int  settings_done = 0;
	int  verdict_tally [0:4] = '{0, 0, 0, 0, 0};
	int  in_gap_pct = 0;
	int  out_stall_pct = 0;
	bit  quiet = 0;
	bit  hold_go = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	int  idle_cycles = 0;

	function automatic site_t home_site();
		return site_t'{home_x, home_y, home_z};
	endfunction

	function automatic site_t goal_site();
		return site_t'{goal_x, goal_y, goal_z};
	endfunction

	function automatic logic [7:0] wrap_inc(logic [7:0] c, int n);
		return 8'((int'(c) + 1) % n);
	endfunction

	function automatic logic [7:0] wrap_dec(logic [7:0] c, int n);
		return 8'((int'(c) + n - 1) % n);
	endfunction

	function automatic void reset_walk_model();
		lat_size = lwsa_pkg::SIZE_RST;
		home_x = lwsa_pkg::COORD_RST; home_y = lwsa_pkg::COORD_RST;
		home_z = lwsa_pkg::COORD_RST;
		goal_x = lwsa_pkg::COORD_RST; goal_y = lwsa_pkg::COORD_RST;
		goal_z = lwsa_pkg::COORD_RST;
		walk_live = 0;
		trail_len = 1;
		here = home_site();
		trail[0] = here;
		verdict_now = lwsa_pkg::ST_OK;
		steps_taken = 0;
	endfunction

	function automatic void apply_setting(logic [lwsa_pkg::CFG_IDX_W-1:0] idx,
			logic [lwsa_pkg::CFG_W-1:0] val);
		case (idx)
			lwsa_pkg::CFG_SIZE:     lat_size = val;
			lwsa_pkg::CFG_START_X:  home_x = val;
			lwsa_pkg::CFG_START_Y:  home_y = val;
			lwsa_pkg::CFG_START_Z:  home_z = val;
			lwsa_pkg::CFG_FINISH_X: goal_x = val;
			lwsa_pkg::CFG_FINISH_Y: goal_y = val;
			lwsa_pkg::CFG_FINISH_Z: goal_z = val;
			default: ;
		endcase
	endfunction

	function automatic void advance_walk(input logic [lwsa_pkg::DIR_W-1:0] dir,
			input logic last, output bit got, output verdict_t v);
		int    n;
		site_t nxt;
		bit    hit;
		n = (lat_size == 0) ? 1 : int'(lat_size);
		got = 0;
		v = '0;
		if (!walk_live) begin
			here = home_site();
			trail[0] = here;
			trail_len = 1;
			verdict_now = lwsa_pkg::ST_OK;
			steps_taken = 0;
			walk_live = 1;
		end
		if (steps_taken <= WALK_MAX)
			steps_taken++;
		if (verdict_now == lwsa_pkg::ST_OK) begin
			if (dir == DIR_NUL || dir == DIR_ILL) begin
				verdict_now = lwsa_pkg::ST_BAD;
			end else if (steps_taken > WALK_MAX || trail_len >= WALK_MAX + 1) begin
				verdict_now = lwsa_pkg::ST_LONG;
			end else begin
				nxt = here;
				case (dir)
					lwsa_pkg::DIR_XP: nxt.x = wrap_inc(nxt.x, n);
					lwsa_pkg::DIR_YP: nxt.y = wrap_inc(nxt.y, n);
					lwsa_pkg::DIR_ZP: nxt.z = wrap_inc(nxt.z, n);
					lwsa_pkg::DIR_XN: nxt.x = wrap_dec(nxt.x, n);
					lwsa_pkg::DIR_YN: nxt.y = wrap_dec(nxt.y, n);
					default:          nxt.z = wrap_dec(nxt.z, n);
				endcase
				hit = 0;
				for (int i = 0; i < trail_len; i++)
					if (trail[i] == nxt)
						hit = 1;
				if (hit && !(last && home_site() == goal_site())) begin
					verdict_now = lwsa_pkg::ST_SELF;
				end else begin
					trail[trail_len] = nxt;
					trail_len++;
					here = nxt;
				end
			end
		end
		if (last) begin
			if (verdict_now == lwsa_pkg::ST_OK && here != goal_site())
				verdict_now = lwsa_pkg::ST_END;
			got = 1;
			v.status = verdict_now;
			v.count = lwsa_pkg::COUNT_W'((steps_taken > WALK_MAX) ? WALK_MAX : steps_taken);
			walk_live = 0;
		end
	endfunction

	function automatic logic [lwsa_pkg::DIR_W-1:0] dir_of(int axis, bit neg);
		case (axis)
			0:       return neg ? lwsa_pkg::DIR_XN : lwsa_pkg::DIR_XP;
			1:       return neg ? lwsa_pkg::DIR_YN : lwsa_pkg::DIR_YP;
			default: return neg ? lwsa_pkg::DIR_ZN : lwsa_pkg::DIR_ZP;
		endcase
	endfunction

	function automatic void push_run(int axis, bit neg, int count);
		for (int i = 0; i < count; i++)
			route = {route, move_t'{dir_of(axis, neg), 1'b0}};
	endfunction

	function automatic walk_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (home_site() == goal_site()) begin
			if (r < 45) return WALK_LOOP;
			if (r < 55) return WALK_PATH;
		end else begin
			if (r < 45) return WALK_PATH;
			if (r < 55) return WALK_LOOP;
		end
		if (r < 78) return WALK_RAMBLE;
		if (r < 88) return WALK_SNAKE;
		return WALK_NOISE;
	endfunction

	function automatic void plan_route(walk_kind_t kind);
		int    n, a1, a2, la, lb, cap, len, seg, cur, fin, up, dn, j, tmp;
		bit    s1, s2, flip;
		int    order [3];
		logic [7:0] hc [3];
		logic [7:0] gc [3];
		move_t mv;
		n = (lat_size == 0) ? 1 : int'(lat_size);
		cap = (n - 1 < 12) ? n - 1 : 12;
		if (cap < 1) cap = 1;
		route.delete();
		case (kind)
			WALK_LOOP: begin
				a1 = $urandom_range(0, 2);
				a2 = (a1 + $urandom_range(1, 2)) % 3;
				la = $urandom_range(1, cap);
				lb = $urandom_range(1, cap);
				s1 = 1'($urandom_range(0, 1));
				s2 = 1'($urandom_range(0, 1));
				push_run(a1, s1, la);
				push_run(a2, s2, lb);
				push_run(a1, !s1, la);
				push_run(a2, !s2, lb);
			end
			WALK_PATH: begin
				order = '{0, 1, 2};
				hc = '{home_x, home_y, home_z};
				gc = '{goal_x, goal_y, goal_z};
				for (int k = 0; k < 2; k++) begin
					j = $urandom_range(k, 2);
					tmp = order[k]; order[k] = order[j]; order[j] = tmp;
				end
				for (int k = 0; k < 3; k++) begin
					cur = int'(hc[order[k]]) % n;
					fin = int'(gc[order[k]]) % n;
					up = (fin + n - cur) % n;
					dn = (cur + n - fin) % n;
					flip = ($urandom_range(0, 99) < 25);
					if ((up <= dn) != flip)
						push_run(order[k], 1'b0, up);
					else
						push_run(order[k], 1'b1, dn);
				end
				while (route.size() > 70)
					void'(route.pop_back());
			end
			WALK_RAMBLE: begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++) begin
					mv.dir = ($urandom_range(0, 99) < 5) ?
						lwsa_pkg::DIR_W'($urandom_range(0, 7)) :
						dir_of($urandom_range(0, 2), 1'($urandom_range(0, 1)));
					mv.last = 1'b0;
					route = {route, mv};
				end
			end
			WALK_SNAKE: begin
				len = WALK_MAX + $urandom_range(0, 3);
				seg = (n - 1 < 16) ? n - 1 : 16;
				if (seg < 1) seg = 1;
				j = 0;
				while (route.size() < len) begin
					push_run(0, j[0], seg);
					push_run(1, 1'b0, 1);
					j++;
				end
				while (route.size() > len)
					void'(route.pop_back());
			end
			default: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					route = {route, move_t'{lwsa_pkg::DIR_W'($urandom_range(0, 7)), 1'b0}};
			end
		endcase
		if (route.size() == 0)
			route = {route,
				move_t'{dir_of($urandom_range(0, 2), 1'($urandom_range(0, 1))), 1'b0}};
		if (kind != WALK_NOISE && $urandom_range(0, 99) < 10) begin
			j = $urandom_range(0, route.size() - 1);
			mv = route[j];
			mv.dir = lwsa_pkg::DIR_W'($urandom_range(0, 7));
			route[j] = mv;
		end
		mv = route.pop_back();
		mv.last = 1'b1;
		route = {route, mv};
	endfunction

	task automatic send_step(input logic [lwsa_pkg::DIR_W-1:0] d, input logic l,
			input logic typed, input logic [lwsa_pkg::STATUS_W-1:0] tst,
			input logic [lwsa_pkg::COUNT_W-1:0] tcnt);
		bit       got;
		verdict_t v;
		if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		direction <= d;
		last_step <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		steps_sent++;
		advance_walk(d, l, got, v);
		if (got) begin
			if (typed) begin
				v.status = tst;
				v.count = tcnt;
			end
			pending_verdicts = {pending_verdicts, v};
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lwsa_pkg::CFG_IDX_W-1:0] idx,
			input logic [lwsa_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_setting(idx, val);
	endtask

	task automatic set_lattice(input setting_t s);
		write_reg(lwsa_pkg::CFG_SIZE, s.size);
		write_reg(lwsa_pkg::CFG_START_X, s.hx);
		write_reg(lwsa_pkg::CFG_START_Y, s.hy);
		write_reg(lwsa_pkg::CFG_START_Z, s.hz);
		write_reg(lwsa_pkg::CFG_FINISH_X, s.gx);
		write_reg(lwsa_pkg::CFG_FINISH_Y, s.gy);
		write_reg(lwsa_pkg::CFG_FINISH_Z, s.gz);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_done++;
	endtask

	function automatic setting_t random_setting();
		setting_t s;
		int       sz, span;
		int       h [3];
		int       g [3];
		case ($urandom_range(0, 5))
			0:       sz = 2;
			1:       sz = 255;
			2:       sz = $urandom_range(3, 6);
			3:       sz = $urandom_range(7, 16);
			4:       sz = $urandom_range(17, 254);
			default: sz = $urandom_range(2, 255);
		endcase
		span = (sz - 1 < 6) ? sz - 1 : 6;
		for (int k = 0; k < 3; k++)
			h[k] = ($urandom_range(0, 99) < 85) ? $urandom_range(0, sz - 1) : $urandom_range(0, 254);
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 99) < 10)
				g[k] = $urandom_range(0, 254);
			else
				g[k] = (h[k] % sz + $urandom_range(0, span)) % sz;
		end
		if ($urandom_range(0, 1))
			g = h;
		s = setting_t'{8'(sz), 8'(h[0]), 8'(h[1]), 8'(h[2]), 8'(g[0]), 8'(g[1]), 8'(g[2])};
		return s;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 10;
			2:       return 30;
			default: return 60;
		endcase
	endfunction

	task automatic run_phase(input int budget, input bit squeeze);
		int base;
		base = steps_sent;
		if (!quiet) begin
			in_gap_pct = pick_pct();
			out_stall_pct = pick_pct();
		end
		if (squeeze) begin
			// short walks pile up behind a held verdict
			in_gap_pct = 0;
			hold_go = 1;
		end
		while (steps_sent - base < budget) begin
			plan_route(squeeze ? WALK_RAMBLE : pick_kind());
			while (route.size() != 0) begin
				move_t mv;
				mv = route.pop_front();
				send_step(mv.dir, mv.last, 1'b0, lwsa_pkg::ST_OK, '0);
			end
		end
		settle();
	endtask

	// output side: random stalls, one long hold-off, verdict checks
	always @(posedge clk) begin
		verdict_t v;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (status <= lwsa_pkg::ST_LONG)
					verdict_tally[status]++;
				if (pending_verdicts.size() == 0) begin
					$error("verdict transfer with none pending: status %0d, step_count %0d",
						status, step_count);
					mismatches++;
				end else begin
					v = pending_verdicts.pop_front();
					if (status !== v.status) begin
						$error("status: expected %0d, got %0d", v.status, status);
						mismatches++;
					end
					if (step_count !== v.count) begin
						$error("step_count: expected %0d, got %0d", v.count, step_count);
						mismatches++;
					end
				end
			end
			if (hold_go) begin
				hold_go = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
				stall_left = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d verdicts outstanding",
					idle_cycles, pending_verdicts.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// reset settings: size 10, start and finish both at (4,4,4)
	row_t directed_rows [0:21] = '{
		'{lwsa_pkg::DIR_XP, 1'b1, 1'b1, lwsa_pkg::ST_END,  7'd1},
		'{DIR_NUL,          1'b1, 1'b1, lwsa_pkg::ST_BAD,  7'd1},
		'{DIR_ILL,          1'b1, 1'b1, lwsa_pkg::ST_BAD,  7'd1},
		'{lwsa_pkg::DIR_XP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_YP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_XN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_YN, 1'b1, 1'b1, lwsa_pkg::ST_OK,   7'd4},
		'{lwsa_pkg::DIR_ZP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_ZN, 1'b1, 1'b1, lwsa_pkg::ST_OK,   7'd2},
		'{lwsa_pkg::DIR_ZP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_ZN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_YP, 1'b1, 1'b1, lwsa_pkg::ST_SELF, 7'd3},
		'{lwsa_pkg::DIR_ZN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{DIR_ILL,          1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_XP, 1'b1, 1'b1, lwsa_pkg::ST_BAD,  7'd3},
		'{lwsa_pkg::DIR_XN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_YN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_ZN, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_ZP, 1'b1, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_YP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_ZP, 1'b0, 1'b0, lwsa_pkg::ST_OK,   7'd0},
		'{lwsa_pkg::DIR_XN, 1'b1, 1'b0, lwsa_pkg::ST_OK,   7'd0}
	};

	setting_t edge_settings [0:6] = '{
		'{8'd2,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd1},
		'{8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254},
		'{8'd255, 8'd254, 8'd254, 8'd254, 8'd0,   8'd0,   8'd0},
		'{8'd255, 8'd0,   8'd0,   8'd0,   8'd3,   8'd254, 8'd1},
		'{8'd10,  8'd254, 8'd4,   8'd4,   8'd4,   8'd4,   8'd4},
		'{8'd3,   8'd0,   8'd254, 8'd0,   8'd2,   8'd2,   8'd2}
	};

	initial begin
		int phase_no;
		reset_walk_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_gap_pct = 20;
		out_stall_pct = 20;
		foreach (directed_rows[i])
			send_step(directed_rows[i].dir, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].st, directed_rows[i].cnt);
		settle();

		foreach (edge_settings[i]) begin
			set_lattice(edge_settings[i]);
			run_phase(40, 1'b0);
		end

		phase_no = 0;
		while (steps_sent < 850) begin
			set_lattice(random_setting());
			run_phase(50, phase_no == 1);
			phase_no++;
		end

		quiet = 1;
		in_gap_pct = 0;
		out_stall_pct = 0;
		set_lattice(random_setting());
		run_phase(150, 1'b0);

		$display("covered %0d steps over %0d lattice settings, %0d verdicts checked",
			steps_sent, settings_done,
			verdict_tally[0] + verdict_tally[1] + verdict_tally[2] + verdict_tally[3]
			+ verdict_tally[4]);
		$display("verdicts: ok %0d, self-crossing %0d, wrong end %0d, bad code %0d, too long %0d",
			verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
			verdict_tally[4]);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/lwsa_pkg.sv
design/lwsa_cell.sv
design/lwsa_mod_unit.sv
design/lattice_walk_self_avoid_check.sv
design/lwsa_checker.sv
verif/tb_top.sv
